[sv/direction_sector_quantizer_macros.svh]
// Assertion macros shared by the direction sector quantizer RTL.
// Standalone header; no dependencies.
`ifndef DIRECTION_SECTOR_QUANTIZER_MACROS_SVH
`define DIRECTION_SECTOR_QUANTIZER_MACROS_SVH

`define DSQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`define DSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/dsq_pkg.sv]
// Types, widths and the CORDIC angle table for the direction sector quantizer.
// No dependencies.
package dsq_pkg;

	localparam int TURN_BITS = 24;
	localparam int OFS_W = 25;
	localparam int MAG_W = 24;
	localparam int PRESCALE = 6;
	localparam int XY_W = 35;
	localparam int Z_W = 26;
	localparam int TABLE_LEN = 24;
	localparam int IDX_W = 5;

	localparam logic [TURN_BITS-2:0] QUARTER_TURN = 23'h400000;
	localparam logic [TURN_BITS-1:0] HALF_TURN = 24'h800000;

	typedef logic signed [XY_W-1:0] xy_t;
	typedef logic signed [Z_W-1:0] z_t;

	typedef struct packed {
		logic valid;
		logic q_zero;
		logic p_zero;
		logic dx_neg;
		logic dy_pos;
	} ctl_t;

	function automatic z_t atan_turn(input logic [IDX_W-1:0] idx);
		z_t val;
		case (idx)
			5'd0: val = 26'sd2097152;
			5'd1: val = 26'sd1238021;
			5'd2: val = 26'sd654136;
			5'd3: val = 26'sd332050;
			5'd4: val = 26'sd166669;
			5'd5: val = 26'sd83416;
			5'd6: val = 26'sd41718;
			5'd7: val = 26'sd20860;
			5'd8: val = 26'sd10430;
			5'd9: val = 26'sd5215;
			5'd10: val = 26'sd2608;
			5'd11: val = 26'sd1304;
			5'd12: val = 26'sd652;
			5'd13: val = 26'sd326;
			5'd14: val = 26'sd163;
			5'd15: val = 26'sd81;
			5'd16: val = 26'sd41;
			5'd17: val = 26'sd20;
			5'd18: val = 26'sd10;
			5'd19: val = 26'sd5;
			5'd20: val = 26'sd3;
			5'd21: val = 26'sd1;
			5'd22: val = 26'sd1;
			default: val = 26'sd0;
		endcase
		return val;
	endfunction

endpackage

[sv/dsq_offset.sv]
// Two pipeline stages: offsets from center to target, then magnitudes and sign flags.
// Depends on dsq_pkg.
module dsq_offset (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                request_valid,
	input  logic signed [15:0]  target_x,
	input  logic signed [15:0]  target_y,
	input  logic signed [23:0]  center_x,
	input  logic signed [23:0]  center_y,
	output dsq_pkg::ctl_t       ctl,
	output dsq_pkg::xy_t        x,
	output dsq_pkg::xy_t        y
);

	logic signed [dsq_pkg::OFS_W-1:0] dx_s1, dy_s1;
	logic                             valid_s1;
	logic signed [dsq_pkg::OFS_W-1:0] tx_ext, ty_ext, cx_ext, cy_ext;
	logic [dsq_pkg::MAG_W-1:0]        q_mag, p_mag;
	dsq_pkg::ctl_t                    ctl_s2;
	dsq_pkg::xy_t                     x_s2, y_s2;

	assign tx_ext = {target_x[15], target_x, 8'h00};
	assign ty_ext = {target_y[15], target_y, 8'h00};
	assign cx_ext = {center_x[23], center_x};
	assign cy_ext = {center_y[23], center_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= request_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= tx_ext - cx_ext;
			dy_s1 <= ty_ext - cy_ext;
		end
	end

	always_comb begin
		q_mag = dx_s1[dsq_pkg::OFS_W-1] ? dsq_pkg::MAG_W'(-dx_s1)
			: dx_s1[dsq_pkg::MAG_W-1:0];
		p_mag = dy_s1[dsq_pkg::OFS_W-1] ? dsq_pkg::MAG_W'(-dy_s1)
			: dy_s1[dsq_pkg::MAG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2.valid <= valid_s1;
			ctl_s2.q_zero <= (dx_s1 == '0);
			ctl_s2.p_zero <= (dy_s1 == '0);
			ctl_s2.dx_neg <= dx_s1[dsq_pkg::OFS_W-1];
			ctl_s2.dy_pos <= !dy_s1[dsq_pkg::OFS_W-1] && (dy_s1 != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2 <= dsq_pkg::xy_t'({q_mag, {dsq_pkg::PRESCALE{1'b0}}});
			y_s2 <= dsq_pkg::xy_t'({p_mag, {dsq_pkg::PRESCALE{1'b0}}});
		end
	end

	assign ctl = ctl_s2;
	assign x = x_s2;
	assign y = y_s2;

endmodule

[sv/dsq_cordic_stage.sv]
// One registered vectoring iteration of the CORDIC that finds the first-quadrant angle.
// Depends on dsq_pkg.
module dsq_cordic_stage #(
	parameter int STEP = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  dsq_pkg::ctl_t ctl_in,
	input  dsq_pkg::xy_t  x_in,
	input  dsq_pkg::xy_t  y_in,
	input  dsq_pkg::z_t   z_in,
	output dsq_pkg::ctl_t ctl_out,
	output dsq_pkg::xy_t  x_out,
	output dsq_pkg::xy_t  y_out,
	output dsq_pkg::z_t   z_out
);

	localparam logic [dsq_pkg::IDX_W-1:0] IDX = dsq_pkg::IDX_W'(STEP);

	dsq_pkg::ctl_t ctl_s1;
	dsq_pkg::xy_t  x_s1, y_s1, xs, ys;
	dsq_pkg::z_t   z_s1, step_angle;
	logic          y_pos;

	assign xs = x_in >>> STEP;
	assign ys = y_in >>> STEP;
	assign step_angle = dsq_pkg::atan_turn(IDX);
	assign y_pos = !y_in[dsq_pkg::XY_W-1] && (y_in != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (y_pos) begin
				x_s1 <= x_in + ys;
				y_s1 <= y_in - xs;
				z_s1 <= z_in + step_angle;
			end else begin
				x_s1 <= x_in - ys;
				y_s1 <= y_in + xs;
				z_s1 <= z_in - step_angle;
			end
		end
	end

	assign ctl_out = ctl_s1;
	assign x_out = x_s1;
	assign y_out = y_s1;
	assign z_out = z_s1;

endmodule

[sv/dsq_sector.sv]
// Two pipeline stages: clamp and quadrant resolution, then sector scaling into the result register.
// Depends on dsq_pkg.
module dsq_sector #(
	parameter int SECTORS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  dsq_pkg::ctl_t ctl_in,
	input  dsq_pkg::z_t   z_in,
	output logic          result_valid,
	output logic [8:0]    sector_index
);

	localparam logic [8:0] SECTORS_C = 9'(SECTORS);
	localparam int PROD_W = dsq_pkg::TURN_BITS + 9;

	logic [dsq_pkg::TURN_BITS-2:0] a;
	logic [dsq_pkg::TURN_BITS-1:0] a_ext, angle;
	logic [dsq_pkg::TURN_BITS-1:0] angle_s1;
	logic                          valid_s1;
	logic [PROD_W-1:0]             prod;
	logic [8:0]                    sector_s2;
	logic                          valid_s2;

	always_comb begin
		if (ctl_in.q_zero) begin
			a = dsq_pkg::QUARTER_TURN;
		end else if (ctl_in.p_zero) begin
			a = '0;
		end else if (z_in[dsq_pkg::Z_W-1]) begin
			a = '0;
		end else if (z_in > dsq_pkg::z_t'(dsq_pkg::QUARTER_TURN)) begin
			a = dsq_pkg::QUARTER_TURN;
		end else begin
			a = z_in[dsq_pkg::TURN_BITS-2:0];
		end
		a_ext = {1'b0, a};
		case ({ctl_in.dy_pos, ctl_in.dx_neg})
			2'b00: angle = a_ext;
			2'b01: angle = dsq_pkg::HALF_TURN - a_ext;
			2'b10: angle = '0 - a_ext;
			2'b11: angle = dsq_pkg::HALF_TURN + a_ext;
			default: angle = a_ext;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= ctl_in.valid;
			valid_s2 <= valid_s1;
		end
	end

	assign prod = {9'd0, angle_s1} * {{dsq_pkg::TURN_BITS{1'b0}}, SECTORS_C};

	always_ff @(posedge clk) begin
		if (en) begin
			angle_s1 <= angle;
			sector_s2 <= prod[PROD_W-1:dsq_pkg::TURN_BITS] + 9'd1;
		end
	end

	assign result_valid = valid_s2;
	assign sector_index = sector_s2;

endmodule

[sv/direction_sector_quantizer.sv]
// Top level of the direction sector quantizer: offset stages, CORDIC pipeline, sector stages.
// Depends on dsq_pkg, dsq_offset, dsq_cordic_stage, dsq_sector and the macros header.
//
// Each request carries a target point in whole pixels and a center point with eight
// fraction bits; the block returns the sector, 1 to SECTORS, holding the direction
// from center to target, measured counterclockwise on screen with y growing downward.
// One request is taken every cycle while request_stall is low. A request's result passes
// through two offset stages, one register stage per CORDIC iteration and two
// sector stages. The whole pipeline holds while a valid result is stalled.
`include "direction_sector_quantizer_macros.svh"

module direction_sector_quantizer #(
	parameter int SECTORS = 32,
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               request_valid,
	output logic               request_stall,
	input  logic signed [15:0] target_x,
	input  logic signed [15:0] target_y,
	input  logic signed [23:0] center_x,
	input  logic signed [23:0] center_y,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [8:0]         sector_index
);

	logic          en;
	dsq_pkg::ctl_t ctl_chain [0:CORDIC_STEPS];
	dsq_pkg::xy_t  x_chain [0:CORDIC_STEPS];
	dsq_pkg::xy_t  y_chain [0:CORDIC_STEPS];
	dsq_pkg::z_t   z_chain [0:CORDIC_STEPS];

	assign en = !(result_valid && result_stall);
	assign request_stall = !en;

	dsq_offset u_offset (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.request_valid (request_valid),
		.target_x      (target_x),
		.target_y      (target_y),
		.center_x      (center_x),
		.center_y      (center_y),
		.ctl           (ctl_chain[0]),
		.x             (x_chain[0]),
		.y             (y_chain[0])
	);

	assign z_chain[0] = '0;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		dsq_cordic_stage #(
			.STEP (i)
		) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.ctl_in  (ctl_chain[i]),
			.x_in    (x_chain[i]),
			.y_in    (y_chain[i]),
			.z_in    (z_chain[i]),
			.ctl_out (ctl_chain[i+1]),
			.x_out   (x_chain[i+1]),
			.y_out   (y_chain[i+1]),
			.z_out   (z_chain[i+1])
		);
	end

	dsq_sector #(
		.SECTORS (SECTORS)
	) u_sector (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.ctl_in       (ctl_chain[CORDIC_STEPS]),
		.z_in         (z_chain[CORDIC_STEPS]),
		.result_valid (result_valid),
		.sector_index (sector_index)
	);

	`DSQ_ASSERT_SAME(a_sector_range, clk, arst_n, result_valid, (sector_index >= 9'd1) && (sector_index <= 9'(SECTORS)), "sector index out of range")
	`DSQ_ASSERT_SAME(a_stall_cause, clk, arst_n, request_stall, result_valid && result_stall, "request stalled without a stalled result")
	`DSQ_ASSERT_NEXT(a_entry_valid, clk, arst_n, request_valid && !request_stall, u_offset.valid_s1, "accepted request did not enter the pipeline")

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for direction_sector_quantizer: a clocked driver and monitor
// with random idling and stalls, checked against a built-in sector predictor.
// Depends on the direction_sector_quantizer RTL only.
`timescale 1ns / 1ps

module tb_top;

	localparam int SECTORS = 32;
	localparam int CORDIC_STEPS = 16;
	localparam int LATENCY = CORDIC_STEPS + 4;
	localparam int RANDOM_POINTS = 1280;
	localparam int IDLE_LIMIT = 4000;
	localparam longint TURN = 64'sd1 << 24;
	localparam longint HALF = 64'sd1 << 23;
	localparam longint QUARTER = 64'sd1 << 22;

	typedef struct {
		logic signed [15:0] tx;
		logic signed [15:0] ty;
		logic signed [23:0] cx;
		logic signed [23:0] cy;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic request_valid = 1'b0;
	logic request_stall;
	logic signed [15:0] target_x = '0;
	logic signed [15:0] target_y = '0;
	logic signed [23:0] center_x = '0;
	logic signed [23:0] center_y = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [8:0] sector_index;

	point_t pending_points[$];
	logic [8:0] sector_queue[$];
	point_t next_point;
	logic [8:0] want_sector;
	int total_points = 0;
	int issued = 0;
	int stimulus_phase;
	int failures = 0;
	int idle_cycles = 0;

	longint atan_step_turns [0:23] = '{
		2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
		10430, 5215, 2608, 1304, 652, 326, 163, 81,
		41, 20, 10, 5, 3, 1, 1, 0
	};

	direction_sector_quantizer #(
		.SECTORS(SECTORS),
		.CORDIC_STEPS(CORDIC_STEPS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.request_valid(request_valid),
		.request_stall(request_stall),
		.target_x(target_x),
		.target_y(target_y),
		.center_x(center_x),
		.center_y(center_y),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.sector_index(sector_index)
	);

	function automatic logic [8:0] predict_sector(input logic signed [15:0] tx,
			input logic signed [15:0] ty, input logic signed [23:0] cx,
			input logic signed [23:0] cy);
		longint dx, dy, mag_x, mag_y, x, y, z, xs, ys, quad, ang;
		dx = longint'(tx) * 256 - longint'(cx);
		dy = longint'(ty) * 256 - longint'(cy);
		mag_x = (dx < 0) ? -dx : dx;
		mag_y = (dy < 0) ? -dy : dy;
		if (mag_x == 0) begin
			quad = QUARTER;
		end else if (mag_y == 0) begin
			quad = 0;
		end else begin
			x = mag_x * 64;
			y = mag_y * 64;
			z = 0;
			for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y > 0) begin
					x = x + ys;
					y = y - xs;
					z = z + atan_step_turns[i];
				end else begin
					x = x - ys;
					y = y + xs;
					z = z - atan_step_turns[i];
				end
			end
			if (z < 0)
				z = 0;
			if (z > QUARTER)
				z = QUARTER;
			quad = z;
		end
		if (dy <= 0)
			ang = (dx >= 0) ? quad : HALF - quad;
		else
			ang = (dx >= 0) ? TURN - quad : HALF + quad;
		ang = ang & (TURN - 1);
		return 9'(((ang * SECTORS) >> 24) + 1);
	endfunction

	task automatic add_point(input int tx, input int ty, input int cx, input int cy);
		point_t pt;
		pt.tx = 16'(tx);
		pt.ty = 16'(ty);
		pt.cx = 24'(cx);
		pt.cy = 24'(cy);
		pending_points.push_back(pt);
	endtask

	initial begin
		forever #10 clk = ~clk;
	end

	always_comb stimulus_phase = (total_points == 0) ? 0 : (issued * 4) / total_points;

	// Driver: a held request keeps its payload until it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			request_valid <= 1'b0;
		end else begin
			if (request_valid && !request_stall)
				sector_queue.push_back(predict_sector(target_x, target_y, center_x, center_y));
			if (!request_valid || !request_stall) begin
				if (pending_points.size() != 0 && $urandom_range(99) >=
						((stimulus_phase == 1) ? 69 : (stimulus_phase == 3) ? 19 : 0)) begin
					next_point = pending_points.pop_front();
					target_x <= next_point.tx;
					target_y <= next_point.ty;
					center_x <= next_point.cx;
					center_y <= next_point.cy;
					request_valid <= 1'b1;
					issued <= issued + 1;
				end else begin
					request_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: results are checked in order against the predicted sectors.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (sector_queue.size() == 0) begin
					if (failures < 10)
						$display("unexpected result: sector_index %0d", sector_index);
					failures++;
				end else begin
					want_sector = sector_queue.pop_front();
					if (sector_index !== want_sector) begin
						if (failures < 10)
							$display("sector_index expected %0d actual %0d",
								want_sector, sector_index);
						failures++;
					end
				end
			end
			result_stall <= ($urandom_range(99) <
				((stimulus_phase == 2) ? 69 : (stimulus_phase == 3) ? 19 : 0));
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((request_valid && !request_stall) || (result_valid && !result_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("direction_sector_quantizer: mismatch");
				$finish;
			end
		end
	end

	initial begin
		int mode, off_x, off_y, mag, sx, sy;
		logic signed [15:0] tx, ty;

		// Coincident points, the four axis directions, the field extremes, diagonals and sub-pixel offsets.
		add_point(0, 0, 0, 0);
		add_point(100, 50, 25600, 12800);
		add_point(0, 10, 0, 0);
		add_point(0, -10, 0, 0);
		add_point(10, 0, 0, 0);
		add_point(-10, 0, 0, 0);
		add_point(32767, 32767, -8388608, -8388608);
		add_point(-32768, -32768, 8388607, 8388607);
		add_point(32767, -32768, -8388608, 8388607);
		add_point(-32768, 32767, 8388607, -8388608);
		add_point(-32768, 0, 8388607, 0);
		add_point(0, 32767, 0, -8388608);
		add_point(5, 5, 0, 0);
		add_point(-5, 5, 0, 0);
		add_point(-5, -5, 0, 0);
		add_point(5, -5, 0, 0);
		add_point(0, 0, 1, 0);
		add_point(0, 0, 0, 1);
		add_point(0, 0, 0, -1);
		add_point(0, 0, -1, -1);
		add_point(1000, 1, 256000, 257);
		add_point(1000, 0, 256000, 1);
		add_point(-1, 2, 128, -100);

		for (int n = 0; n < RANDOM_POINTS; n++) begin
			mode = $urandom_range(9);
			tx = 16'($urandom);
			ty = 16'($urandom);
			off_x = int'($urandom_range(4000)) - 2000;
			off_y = int'($urandom_range(4000)) - 2000;
			if (mode <= 3) begin
				add_point(int'(tx), int'(ty), $urandom, $urandom);
			end else if (mode <= 6) begin
				add_point(int'(tx), int'(ty), int'(tx) * 256 + off_x,
					int'(ty) * 256 + off_y);
			end else if (mode == 7) begin
				case ($urandom_range(2))
					0: add_point(int'(tx), int'(ty), int'(tx) * 256, $urandom);
					1: add_point(int'(tx), int'(ty), $urandom, int'(ty) * 256);
					default: add_point(int'(tx), int'(ty), int'(tx) * 256,
						int'(ty) * 256);
				endcase
			end else begin
				mag = $urandom_range(4000000, 1);
				sx = $urandom_range(1) ? 1 : -1;
				sy = $urandom_range(1) ? 1 : -1;
				add_point(int'(tx), int'(ty), int'(tx) * 256 - sx * mag,
					int'(ty) * 256 - sy * (mag + off_y / 100));
			end
		end
		total_points = pending_points.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		@(posedge clk);
		while (pending_points.size() != 0 || request_valid || sector_queue.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (sector_queue.size() != 0) begin
			$display("%0d predicted sectors never arrived", sector_queue.size());
			failures++;
		end
		if (failures == 0)
			$display("direction_sector_quantizer: match");
		else
			$display("direction_sector_quantizer: mismatch");
		$finish;
	end

endmodule
